// ----- sv/csp_pkg.sv -----
// Package for the color string parser: constants, types and the color name table.
package csp_pkg;

   localparam int MAX_NAME_LENGTH = 20;
   localparam int NAME_COUNT      = 147;
   localparam int TABLE_SIZE      = 147;
   localparam int NAME_WIDTH      = 21;
   localparam int CHAR_BITS       = 8;
   localparam int COUNT_BITS      = 5;
   localparam int HEX_BITS        = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = 5'd31;
   localparam logic [COUNT_BITS-1:0] LEN_SHORT   = 5'd4;
   localparam logic [COUNT_BITS-1:0] LEN_LONG    = 5'd7;
   localparam logic [COUNT_BITS-1:0] LEN_ALPHA   = 5'd9;
   localparam logic [CHAR_BITS-1:0]  HASH_CHAR   = 8'h23;
   localparam logic [7:0]            NIBBLE_DUP  = 8'h11;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last_char;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       alpha_dropped;
   } rsp_type;

   // Summary of one finished string, passed from the scanner to the resolver
   typedef struct packed {
      logic [COUNT_BITS-1:0] char_count;
      logic [HEX_BITS-1:0]   hex_value;
      logic                  starts_with_hash;
      logic                  all_hex_digits;
      logic                  all_letters;
      logic [NAME_COUNT-1:0] name_alive;
   } scan_type;

   typedef struct packed {
      logic [NAME_WIDTH*8-1:0] text;
      logic [23:0]             rgb;
   } entry_type;

   function automatic entry_type mk(input string s, input logic [23:0] rgb);
      entry_type e;
      e.text = '0;
      e.rgb  = rgb;
      for (int k = 0; k < NAME_WIDTH; k++) begin
         if (k < s.len()) e.text[k*8 +: 8] = s[k];
      end
      return e;
   endfunction

   function automatic entry_type color_entry(input int i);
      case (i)
         0: return mk("aliceblue", 24'hf0f8ff);
         1: return mk("antiquewhite", 24'hfaebd7);
         2: return mk("aqua", 24'h00ffff);
         3: return mk("aquamarine", 24'h7fffd4);
         4: return mk("azure", 24'hf0ffff);
         5: return mk("beige", 24'hf5f5dc);
         6: return mk("bisque", 24'hffe4c4);
         7: return mk("black", 24'h000000);
         8: return mk("blanchedalmond", 24'hffebcd);
         9: return mk("blue", 24'h0000ff);
         10: return mk("blueviolet", 24'h8a2be2);
         11: return mk("brown", 24'ha52a2a);
         12: return mk("burlywood", 24'hdeb887);
         13: return mk("cadetblue", 24'h5f9ea0);
         14: return mk("chartreuse", 24'h7fff00);
         15: return mk("chocolate", 24'hd2691e);
         16: return mk("coral", 24'hff7f50);
         17: return mk("cornflowerblue", 24'h6495ed);
         18: return mk("cornsilk", 24'hfff8dc);
         19: return mk("crimson", 24'hdc143c);
         20: return mk("cyan", 24'h00ffff);
         21: return mk("darkblue", 24'h00008b);
         22: return mk("darkcyan", 24'h008b8b);
         23: return mk("darkgoldenrod", 24'hb8860b);
         24: return mk("darkgray", 24'ha9a9a9);
         25: return mk("darkgrey", 24'ha9a9a9);
         26: return mk("darkgreen", 24'h006400);
         27: return mk("darkkhaki", 24'hbdb76b);
         28: return mk("darkmagenta", 24'h8b008b);
         29: return mk("darkolivegreen", 24'h556b2f);
         30: return mk("darkorange", 24'hff8c00);
         31: return mk("darkorchid", 24'h9932cc);
         32: return mk("darkred", 24'h8b0000);
         33: return mk("darksalmon", 24'he9967a);
         34: return mk("darkseagreen", 24'h8fbc8f);
         35: return mk("darkslateblue", 24'h483d8b);
         36: return mk("darkslategray", 24'h2f4f4f);
         37: return mk("darkslategrey", 24'h2f4f4f);
         38: return mk("darkturquoise", 24'h00ced1);
         39: return mk("darkviolet", 24'h9400d3);
         40: return mk("deeppink", 24'hff1493);
         41: return mk("deepskyblue", 24'h00bfff);
         42: return mk("dimgray", 24'h696969);
         43: return mk("dimgrey", 24'h696969);
         44: return mk("dodgerblue", 24'h1e90ff);
         45: return mk("firebrick", 24'hb22222);
         46: return mk("floralwhite", 24'hfffaf0);
         47: return mk("forestgreen", 24'h228b22);
         48: return mk("fuchsia", 24'hff00ff);
         49: return mk("gainsboro", 24'hdcdcdc);
         50: return mk("ghostwhite", 24'hf8f8ff);
         51: return mk("gold", 24'hffd700);
         52: return mk("goldenrod", 24'hdaa520);
         53: return mk("gray", 24'h808080);
         54: return mk("grey", 24'h808080);
         55: return mk("green", 24'h008000);
         56: return mk("greenyellow", 24'hadff2f);
         57: return mk("honeydew", 24'hf0fff0);
         58: return mk("hotpink", 24'hff69b4);
         59: return mk("indianred", 24'hcd5c5c);
         60: return mk("indigo", 24'h4b0082);
         61: return mk("ivory", 24'hfffff0);
         62: return mk("khaki", 24'hf0e68c);
         63: return mk("lavender", 24'he6e6fa);
         64: return mk("lavenderblush", 24'hfff0f5);
         65: return mk("lawngreen", 24'h7cfc00);
         66: return mk("lemonchiffon", 24'hfffacd);
         67: return mk("lightblue", 24'hadd8e6);
         68: return mk("lightcoral", 24'hf08080);
         69: return mk("lightcyan", 24'he0ffff);
         70: return mk("lightgoldenrodyellow", 24'hfafad2);
         71: return mk("lightgray", 24'hd3d3d3);
         72: return mk("lightgrey", 24'hd3d3d3);
         73: return mk("lightgreen", 24'h90ee90);
         74: return mk("lightpink", 24'hffb6c1);
         75: return mk("lightsalmon", 24'hffa07a);
         76: return mk("lightseagreen", 24'h20b2aa);
         77: return mk("lightskyblue", 24'h87cefa);
         78: return mk("lightslategray", 24'h778899);
         79: return mk("lightslategrey", 24'h778899);
         80: return mk("lightsteelblue", 24'hb0c4de);
         81: return mk("lightyellow", 24'hffffe0);
         82: return mk("lime", 24'h00ff00);
         83: return mk("limegreen", 24'h32cd32);
         84: return mk("linen", 24'hfaf0e6);
         85: return mk("magenta", 24'hff00ff);
         86: return mk("maroon", 24'h800000);
         87: return mk("mediumaquamarine", 24'h66cdaa);
         88: return mk("mediumblue", 24'h0000cd);
         89: return mk("mediumorchid", 24'hba55d3);
         90: return mk("mediumpurple", 24'h9370db);
         91: return mk("mediumseagreen", 24'h3cb371);
         92: return mk("mediumslateblue", 24'h7b68ee);
         93: return mk("mediumspringgreen", 24'h00fa9a);
         94: return mk("mediumturquoise", 24'h48d1cc);
         95: return mk("mediumvioletred", 24'hc71585);
         96: return mk("midnightblue", 24'h191970);
         97: return mk("mintcream", 24'hf5fffa);
         98: return mk("mistyrose", 24'hffe4e1);
         99: return mk("moccasin", 24'hffe4b5);
         100: return mk("navajowhite", 24'hffdead);
         101: return mk("navy", 24'h000080);
         102: return mk("oldlace", 24'hfdf5e6);
         103: return mk("olive", 24'h808000);
         104: return mk("olivedrab", 24'h6b8e23);
         105: return mk("orange", 24'hffa500);
         106: return mk("orangered", 24'hff4500);
         107: return mk("orchid", 24'hda70d6);
         108: return mk("palegoldenrod", 24'heee8aa);
         109: return mk("palegreen", 24'h98fb98);
         110: return mk("paleturquoise", 24'hafeeee);
         111: return mk("palevioletred", 24'hdb7093);
         112: return mk("papayawhip", 24'hffefd5);
         113: return mk("peachpuff", 24'hffdab9);
         114: return mk("peru", 24'hcd853f);
         115: return mk("pink", 24'hffc0cb);
         116: return mk("plum", 24'hdda0dd);
         117: return mk("powderblue", 24'hb0e0e6);
         118: return mk("purple", 24'h800080);
         119: return mk("red", 24'hff0000);
         120: return mk("rosybrown", 24'hbc8f8f);
         121: return mk("royalblue", 24'h4169e1);
         122: return mk("saddlebrown", 24'h8b4513);
         123: return mk("salmon", 24'hfa8072);
         124: return mk("sandybrown", 24'hf4a460);
         125: return mk("seagreen", 24'h2e8b57);
         126: return mk("seashell", 24'hfff5ee);
         127: return mk("sienna", 24'ha0522d);
         128: return mk("silver", 24'hc0c0c0);
         129: return mk("skyblue", 24'h87ceeb);
         130: return mk("slateblue", 24'h6a5acd);
         131: return mk("slategray", 24'h708090);
         132: return mk("slategrey", 24'h708090);
         133: return mk("snow", 24'hfffafa);
         134: return mk("springgreen", 24'h00ff7f);
         135: return mk("steelblue", 24'h4682b4);
         136: return mk("tan", 24'hd2b48c);
         137: return mk("teal", 24'h008080);
         138: return mk("thistle", 24'hd8bfd8);
         139: return mk("tomato", 24'hff6347);
         140: return mk("turquoise", 24'h40e0d0);
         141: return mk("violet", 24'hee82ee);
         142: return mk("wheat", 24'hf5deb3);
         143: return mk("white", 24'hffffff);
         144: return mk("whitesmoke", 24'hf5f5f5);
         145: return mk("yellow", 24'hffff00);
         146: return mk("yellowgreen", 24'h9acd32);
         default: return mk("", 24'h000000);
      endcase
   endfunction

   // Name length, counted up to the first zero byte
   function automatic logic [COUNT_BITS-1:0] entry_length(input int i);
      entry_type e;
      logic [COUNT_BITS-1:0] n;
      logic stop;
      e = color_entry(i);
      n = '0;
      stop = 1'b0;
      for (int k = 0; k < NAME_WIDTH; k++) begin
         if (!stop && e.text[k*8 +: 8] != 8'h00) n = n + 1'b1;
         else stop = 1'b1;
      end
      return n;
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [CHAR_BITS-1:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
   endfunction

   function automatic logic is_hex(input logic [CHAR_BITS-1:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

endpackage

// ----- sv/csp_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface csp_req_if;
   import csp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface csp_rsp_if;
   import csp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/csp_scan.sv -----
// Per-character scanner: count, hex accumulator, flags and name-match vector.
module csp_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  csp_pkg::req_type  req,
   output csp_pkg::scan_type scan
);
   import csp_pkg::*;

   logic [COUNT_BITS-1:0] char_count_ff, char_count_in;
   logic [HEX_BITS-1:0]   hex_value_ff, hex_value_in;
   logic                  hash_ff, hash_in;
   logic                  all_hex_ff, all_hex_in;
   logic                  all_let_ff, all_let_in;
   logic [NAME_COUNT-1:0] alive_ff, alive_in;
   logic                  letter;
   logic [CHAR_BITS-1:0]  lower;
   logic [CHAR_BITS-1:0]  table_char [NAME_COUNT];
   entry_type             ent;

   assign letter = (req.character >= "a" && req.character <= "z")
                || (req.character >= "A" && req.character <= "Z");
   assign lower  = letter ? (req.character | 8'h20) : req.character;

   // Character of each name at the current position
   always_comb begin
      for (int i = 0; i < NAME_COUNT; i++) begin
         ent = color_entry(i);
         table_char[i] = 8'h00;
         for (int k = 0; k < MAX_NAME_LENGTH; k++) begin
            if (char_count_ff == COUNT_BITS'(k)) table_char[i] = ent.text[k*8 +: 8];
         end
      end
   end

   // Updated state including the current character
   always_comb begin
      char_count_in = (char_count_ff < COUNT_LIMIT) ? char_count_ff + 1'b1 : char_count_ff;
      hash_in       = hash_ff;
      all_hex_in    = all_hex_ff;
      hex_value_in  = hex_value_ff;
      if (char_count_ff == '0) begin
         hash_in = (req.character == HASH_CHAR);
      end else begin
         all_hex_in   = all_hex_ff & is_hex(req.character);
         hex_value_in = {hex_value_ff[HEX_BITS-5:0], hex_nibble(req.character)};
      end
      all_let_in = all_let_ff & letter;
      for (int i = 0; i < NAME_COUNT; i++) begin
         alive_in[i] = alive_ff[i] && (i < TABLE_SIZE)
                    && (char_count_ff < COUNT_BITS'(MAX_NAME_LENGTH))
                    && (table_char[i] == lower) && (lower != 8'h00);
      end
   end

   assign scan.char_count       = char_count_in;
   assign scan.hex_value        = hex_value_in;
   assign scan.starts_with_hash = hash_in;
   assign scan.all_hex_digits   = all_hex_in;
   assign scan.all_letters      = all_let_in;
   assign scan.name_alive       = alive_in;

   // State registers, cleared on reset and at the end of every string
   always_ff @(posedge clock) begin
      if (reset || (step && req.last_char)) begin
         char_count_ff <= '0;
         hex_value_ff  <= '0;
         hash_ff       <= 1'b0;
         all_hex_ff    <= 1'b1;
         all_let_ff    <= 1'b1;
         alive_ff      <= '1;
      end else if (step) begin
         char_count_ff <= char_count_in;
         hex_value_ff  <= hex_value_in;
         hash_ff       <= hash_in;
         all_hex_ff    <= all_hex_in;
         all_let_ff    <= all_let_in;
         alive_ff      <= alive_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (step && !req.last_char && char_count_ff == COUNT_LIMIT) |=> char_count_ff == COUNT_LIMIT)
      else $error("count left saturation");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (step && req.last_char) |=> (char_count_ff == '0 && alive_ff == '1))
      else $error("state not cleared after last character");
   a_long_dead: assert property (@(posedge clock) disable iff (reset)
      (char_count_ff >= COUNT_BITS'(MAX_NAME_LENGTH)) |-> alive_in == '0)
      else $error("name alive past max length");
`endif
endmodule

// ----- sv/csp_resolve.sv -----
// Resolver: turns a finished string summary into a color response.
module csp_resolve (
   input  csp_pkg::scan_type scan,
   output csp_pkg::rsp_type  rsp
);
   import csp_pkg::*;

   logic [23:0] name_rgb;
   logic        name_hit;
   logic        hex_ok;
   entry_type   ent;

   // First live name whose length equals the string length
   always_comb begin
      name_hit = 1'b0;
      name_rgb = '0;
      ent      = '0;
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
         if (scan.name_alive[i] && i < TABLE_SIZE && entry_length(i) == scan.char_count) begin
            ent      = color_entry(i);
            name_hit = 1'b1;
            name_rgb = ent.rgb;
         end
      end
   end

   assign hex_ok = scan.starts_with_hash && scan.all_hex_digits;

   always_comb begin
      rsp = '0;
      if (hex_ok && scan.char_count == LEN_SHORT) begin
         rsp.found = 1'b1;
         rsp.red   = 8'(scan.hex_value[11:8] * NIBBLE_DUP);
         rsp.green = 8'(scan.hex_value[7:4] * NIBBLE_DUP);
         rsp.blue  = 8'(scan.hex_value[3:0] * NIBBLE_DUP);
      end else if (hex_ok && scan.char_count == LEN_LONG) begin
         rsp.found = 1'b1;
         rsp.red   = scan.hex_value[23:16];
         rsp.green = scan.hex_value[15:8];
         rsp.blue  = scan.hex_value[7:0];
      end else if (hex_ok && scan.char_count == LEN_ALPHA) begin
         rsp.found         = 1'b1;
         rsp.alpha_dropped = 1'b1;
         rsp.red           = scan.hex_value[31:24];
         rsp.green         = scan.hex_value[23:16];
         rsp.blue          = scan.hex_value[15:8];
      end else if (scan.all_letters && name_hit) begin
         rsp.found = 1'b1;
         rsp.red   = name_rgb[23:16];
         rsp.green = name_rgb[15:8];
         rsp.blue  = name_rgb[7:0];
      end
   end
endmodule

// ----- sv/color_string_parser.sv -----
// Top level of the color string parser.
// A response appears in the cycle after the request carrying the last character is accepted.
// Throughput: one request per cycle while no response is stalled; the scan registers update on every accepted request.
// The response register frees in the cycle it is taken, so requests keep flowing.
// Reset (synchronous, active high) clears the scan state and drops any pending response.
module color_string_parser (
   input logic  clock,
   input logic  reset,
   csp_req_if.sink   req,
   csp_rsp_if.source rsp
);
   import csp_pkg::*;

   scan_type scan;
   rsp_type  result;
   logic     step;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign step      = req.valid && req.ready;

   csp_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req.payload),
      .scan  (scan)
   );

   csp_resolve u_resolve (
      .scan (scan),
      .rsp  (result)
   );

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (step && req.payload.last_char) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step && req.payload.last_char) rsp_data_ff <= result;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while response stalled");
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (step && req.payload.last_char) |=> rsp_valid_ff)
      else $error("response missing after last character");
   a_zero_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |->
      (rsp_data_ff.red == 8'h00 && rsp_data_ff.green == 8'h00 && rsp_data_ff.blue == 8'h00))
      else $error("color set on not found");
`endif
endmodule
